[rtl/core/ppe_pkg.sv]
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types and constants of the led pixel pulse encoder.
// ----------------------------------------------------------------------------
package ppe_pkg;

    // field widths
    localparam int TICK_W    = 15;
    localparam int WORD_W    = 32;
    localparam int CHAN_W    = 8;
    localparam int BITS_W    = 4 * CHAN_W;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 3;

    // bit counts of one pixel
    localparam logic [CNT_W-1:0] BITS_THREE_BYTES = CNT_W'(3 * CHAN_W);
    localparam logic [CNT_W-1:0] BITS_FOUR_BYTES  = CNT_W'(4 * CHAN_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TIME = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTES = 3'd5;

    // register reset values
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 15'd8;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST   = 15'd17;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 15'd16;
    localparam logic [TICK_W-1:0] ONE_LOW_RST    = 15'd9;
    localparam logic [TICK_W-1:0] RESET_TIME_RST = 15'd1000;

    // timing registers seen by the serializer
    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] reset_time;
    } ppe_cfg_t;

    // one classified pixel: bits left aligned, sent msb first
    typedef struct packed {
        logic [BITS_W-1:0] bits;
        logic [CNT_W-1:0]  nbits;
        logic              last;
    } ppe_item_t;

endpackage

[rtl/core/ppe_front.sv]
// ----------------------------------------------------------------------------
// ppe_front
// Pixel intake: reorders the colors to wire order and sets the bit count.
// ----------------------------------------------------------------------------
module ppe_front
    import ppe_pkg::*;
(
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    input  logic [CHAN_W-1:0] white,
    input  logic              last_pixel,
    input  logic              four_bytes,
    output ppe_item_t         item
);

    // green, red, blue, then white only in four-byte mode
    always_comb
    begin
        item.bits  = {green, red, blue, (four_bytes ? white : {CHAN_W{1'b0}})};
        item.nbits = four_bytes ? BITS_FOUR_BYTES : BITS_THREE_BYTES;
        item.last  = last_pixel;
    end

endmodule

[rtl/core/ppe_queue.sv]
// ----------------------------------------------------------------------------
// ppe_queue
// Short queue of classified pixels between intake and serializer.
// ----------------------------------------------------------------------------
module ppe_queue
    import ppe_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  ppe_item_t wr_item,
    input  logic      rd_en,
    output ppe_item_t rd_item,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);

    ppe_item_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_Q-1:0]       count_reg, count_next;
    logic                   do_wr, do_rd;

    assign full    = (count_reg == CNT_Q'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[rtl/core/ppe_back.sv]
// ----------------------------------------------------------------------------
// ppe_back
// Serializer: one pulse word per color bit, then the end word of a strand.
// ----------------------------------------------------------------------------
module ppe_back
    import ppe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ppe_cfg_t          cfg,
    input  ppe_item_t         q_item,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [WORD_W-1:0] pulse_word,
    output logic              last_of_pixel
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BITS = 3'b010,
        ST_END  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [BITS_W-1:0]   shift_reg, shift_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic                lop_reg, lop_next;

    logic                out_free;
    logic [BITS_W-1:0]   src_bits;
    logic [CNT_W-1:0]    src_cnt;
    logic                src_last;
    logic                cur_bit, final_bit;
    logic [TICK_W-1:0]   high_t, low_t;
    logic [WORD_W-1:0]   bit_word;

    assign out_free      = !out_valid_reg || pop;
    assign empty         = !out_valid_reg;
    assign pulse_word    = word_reg;
    assign last_of_pixel = lop_reg;

    // current bit comes from the held pixel or straight from the queue head
    assign src_bits  = (state_reg == ST_BITS) ? shift_reg : q_item.bits;
    assign src_cnt   = (state_reg == ST_BITS) ? cnt_reg   : q_item.nbits;
    assign src_last  = (state_reg == ST_BITS) ? last_reg  : q_item.last;
    assign cur_bit   = src_bits[BITS_W-1];
    assign final_bit = (src_cnt == CNT_W'(1));

    // pulse word of the current bit
    always_comb
    begin
        high_t = cur_bit ? cfg.one_high : cfg.zero_high;
        if (final_bit && src_last)
        begin
            low_t = cfg.reset_time;
        end
        else
        begin
            low_t = cur_bit ? cfg.one_low : cfg.zero_low;
        end
        bit_word = {1'b0, low_t, 1'b1, high_t};
    end

    // sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        word_next      = word_reg;
        lop_next       = lop_reg;
        q_pop          = 1'b0;
        unique case (state_reg) inside
            ST_IDLE, ST_BITS:
            begin
                if (out_free && (state_reg == ST_BITS || !q_empty))
                begin
                    q_pop          = (state_reg == ST_IDLE);
                    shift_next     = src_bits << 1;
                    cnt_next       = src_cnt - 1'b1;
                    last_next      = src_last;
                    out_valid_next = 1'b1;
                    word_next      = bit_word;
                    lop_next       = final_bit && !src_last;
                    if (final_bit)
                    begin
                        state_next = src_last ? ST_END : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_BITS;
                    end
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    word_next      = '0;
                    lop_next       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
        last_reg  <= last_next;
        word_reg  <= word_next;
        lop_reg   <= lop_next;
    end

endmodule

[rtl/core/led_pixel_pulse_encoder_core.sv]
// ----------------------------------------------------------------------------
// led_pixel_pulse_encoder_core
// Turns pixels into one-wire pulse words, one word per color bit.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  pixel     in         push / full          red green blue white last_pixel
//  pulse     out        pop / empty          pulse_word last_of_pixel
//  config    in         cfg_wr_en            cfg_index cfg_data
//
//  The serializer sends one pulse word per cycle unless stalled; a pixel
//  gives 24 words (32 in four-byte mode), the final pixel one end word more.
//  Intake takes a pixel per cycle while the pixel queue has room.
//  A stalled pop holds the output word; the serializer waits behind it.
//  Reset empties the queue and loads the default timing registers.
// ----------------------------------------------------------------------------
module led_pixel_pulse_encoder_core
    import ppe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [CHAN_W-1:0]    red,
    input  logic [CHAN_W-1:0]    green,
    input  logic [CHAN_W-1:0]    blue,
    input  logic [CHAN_W-1:0]    white,
    input  logic                 last_pixel,
    output logic                 empty,
    input  logic                 pop,
    output logic [WORD_W-1:0]    pulse_word,
    output logic                 last_of_pixel,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    ppe_cfg_t  cfg_reg;
    logic      four_bytes_reg;
    ppe_item_t front_item;
    ppe_item_t head_item;
    logic      q_empty;
    logic      q_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_high  <= ZERO_HIGH_RST;
            cfg_reg.zero_low   <= ZERO_LOW_RST;
            cfg_reg.one_high   <= ONE_HIGH_RST;
            cfg_reg.one_low    <= ONE_LOW_RST;
            cfg_reg.reset_time <= RESET_TIME_RST;
            four_bytes_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ZERO_HIGH:  cfg_reg.zero_high  <= cfg_data;
                CFG_ZERO_LOW:   cfg_reg.zero_low   <= cfg_data;
                CFG_ONE_HIGH:   cfg_reg.one_high   <= cfg_data;
                CFG_ONE_LOW:    cfg_reg.one_low    <= cfg_data;
                CFG_RESET_TIME: cfg_reg.reset_time <= cfg_data;
                CFG_FOUR_BYTES: four_bytes_reg     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // pixel intake
    ppe_front u_front (
        .red        (red),
        .green      (green),
        .blue       (blue),
        .white      (white),
        .last_pixel (last_pixel),
        .four_bytes (four_bytes_reg),
        .item       (front_item)
    );

    // pixel queue
    ppe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_item (front_item),
        .rd_en   (q_pop),
        .rd_item (head_item),
        .full    (full),
        .empty   (q_empty)
    );

    // bit serializer
    ppe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_item        (head_item),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .pulse_word    (pulse_word),
        .last_of_pixel (last_of_pixel)
    );

endmodule
